// ----- hdl/turtle_3d_command_interpreter_macros.svh -----
// Assertion macros for the 3D turtle command interpreter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TURTLE_3D_COMMAND_INTERPRETER_MACROS_SVH
`define TURTLE_3D_COMMAND_INTERPRETER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define T3DCI_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define T3DCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/t3dci_pkg.sv -----
// Shared types, constants and command codes of the 3D turtle interpreter.
// No dependencies.
package t3dci_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [31:0] fix_t;
    typedef logic signed [15:0] q14_t;

    localparam fix_t STEP_RST = 32'sd65536;
    localparam q14_t Q_ONE = 16'sd16384;
    localparam q14_t Q_ZERO = 16'sd0;

    typedef enum logic [2:0] {
        CFG_STEP   = 3'd0,
        CFG_CTURN  = 3'd1,
        CFG_STURN  = 3'd2,
        CFG_CHEAD  = 3'd3,
        CFG_SHEAD  = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        fix_t step;
        q14_t cturn;
        q14_t sturn;
        q14_t chead;
        q14_t shead;
    } cfg_t;

    localparam logic [7:0] CH_DRAW   = 8'h46;
    localparam logic [7:0] CH_MOVE   = 8'h66;
    localparam logic [7:0] CH_YAW_P  = 8'h2B;
    localparam logic [7:0] CH_YAW_N  = 8'h2D;
    localparam logic [7:0] CH_PIT_P  = 8'h26;
    localparam logic [7:0] CH_PIT_N  = 8'h5E;
    localparam logic [7:0] CH_ROL_P  = 8'h2F;
    localparam logic [7:0] CH_ROL_N  = 8'h5C;
    localparam logic [7:0] CH_FLIP   = 8'h7C;
    localparam logic [7:0] CH_PUSH   = 8'h5B;
    localparam logic [7:0] CH_POP    = 8'h5D;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_MOVE = 3'd1,
        OP_TURN = 3'd2,
        OP_PUSH = 3'd3,
        OP_POP  = 3'd4
    } op_kind_e;

    typedef enum logic [1:0] {
        AX_HEAD = 2'd0,
        AX_LEFT = 2'd1,
        AX_UP   = 2'd2,
        AX_FLIP = 2'd3
    } axis_e;

    typedef struct packed {
        op_kind_e kind;
        logic     draw;
        axis_e    axis;
        logic     neg;
        logic     new_string;
    } op_t;

    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
        q14_t qw;
        q14_t qx;
        q14_t qy;
        q14_t qz;
    } turtle_t;

endpackage

// ----- hdl/t3dci_cmd_if.sv -----
// Command channel: one command byte and the new-string flag per beat.
// Depends on nothing.
interface t3dci_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] command;
    logic       new_string;

    modport source (output valid, output command, output new_string, input ready);
    modport sink (input valid, input command, input new_string, output ready);
endinterface

// ----- hdl/t3dci_seg_if.sv -----
// Segment channel: one drawn line segment per beat.
// Depends on t3dci_pkg.
interface t3dci_seg_if;
    logic            valid;
    logic            ready;
    t3dci_pkg::fix_t seg_start_x;
    t3dci_pkg::fix_t seg_start_y;
    t3dci_pkg::fix_t seg_start_z;
    t3dci_pkg::fix_t seg_end_x;
    t3dci_pkg::fix_t seg_end_y;
    t3dci_pkg::fix_t seg_end_z;

    modport source (output valid, output seg_start_x, output seg_start_y, output seg_start_z,
                    output seg_end_x, output seg_end_y, output seg_end_z, input ready);
    modport sink (input valid, input seg_start_x, input seg_start_y, input seg_start_z,
                  input seg_end_x, input seg_end_y, input seg_end_z, output ready);
endinterface

// ----- hdl/t3dci_front.sv -----
// Front end: accepts command beats, decodes them and holds them in a two-entry queue.
// Depends on t3dci_pkg and t3dci_cmd_if.
module t3dci_front
(
    input  logic               clk,
    input  logic               rst_n,
    t3dci_cmd_if.sink          cmd,
    output logic               q_valid,
    output t3dci_pkg::op_t     q_op,
    input  logic               q_pop
);

    t3dci_pkg::op_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    t3dci_pkg::op_t dec;

    always_comb
    begin
        dec = '{kind: t3dci_pkg::OP_NOP, draw: 1'b0, axis: t3dci_pkg::AX_HEAD,
                neg: 1'b0, new_string: cmd.new_string};
        unique case (cmd.command)
            t3dci_pkg::CH_DRAW:
            begin
                dec.kind = t3dci_pkg::OP_MOVE;
                dec.draw = 1'b1;
            end
            t3dci_pkg::CH_MOVE:  dec.kind = t3dci_pkg::OP_MOVE;
            t3dci_pkg::CH_YAW_P:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_UP;
            end
            t3dci_pkg::CH_YAW_N:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_UP;
                dec.neg  = 1'b1;
            end
            t3dci_pkg::CH_PIT_P:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_LEFT;
            end
            t3dci_pkg::CH_PIT_N:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_LEFT;
                dec.neg  = 1'b1;
            end
            t3dci_pkg::CH_ROL_P:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_HEAD;
            end
            t3dci_pkg::CH_ROL_N:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_HEAD;
                dec.neg  = 1'b1;
            end
            t3dci_pkg::CH_FLIP:
            begin
                dec.kind = t3dci_pkg::OP_TURN;
                dec.axis = t3dci_pkg::AX_FLIP;
            end
            t3dci_pkg::CH_PUSH:  dec.kind = t3dci_pkg::OP_PUSH;
            t3dci_pkg::CH_POP:   dec.kind = t3dci_pkg::OP_POP;
            default:             dec.kind = t3dci_pkg::OP_NOP;
        endcase
    end

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_op      = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- hdl/t3dci_back.sv -----
// Back end: executes decoded commands on the turtle state, stack memory and segment output.
// Depends on t3dci_pkg and t3dci_seg_if.
module t3dci_back
#(
    parameter int STACK_DEPTH = t3dci_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  t3dci_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  t3dci_pkg::op_t     q_op,
    output logic               q_pop,
    output logic               busy,
    t3dci_seg_if.source        seg
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_TSUM  = 7'b0000100,
        S_HSUM  = 7'b0001000,
        S_MMUL  = 7'b0010000,
        S_MSUM  = 7'b0100000,
        S_POPLD = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    t3dci_pkg::op_t    op_reg;
    logic signed [16:0] tq_reg [4];
    t3dci_pkg::q14_t   o_reg [4], o_next [4];
    t3dci_pkg::fix_t   pos_reg [3], pos_next [3];
    logic [CW-1:0]     cnt_reg, cnt_next, cnt_dec;
    logic signed [32:0] prod_reg [4][4];
    logic signed [20:0] h_reg [3];
    logic signed [52:0] mv_reg [3];
    t3dci_pkg::turtle_t rd_data_reg;
    t3dci_pkg::turtle_t push_data;
    t3dci_pkg::turtle_t stack_mem [STACK_DEPTH];
    t3dci_pkg::fix_t   sst_reg [3], sst_next [3];
    t3dci_pkg::fix_t   sen_reg [3], sen_next [3];
    logic              seg_valid_reg, seg_valid_next;
    logic signed [34:0] rsum [4];
    logic signed [34:0] hsum [3];
    logic signed [36:0] rrnd [4];
    logic signed [36:0] hrnd [3];
    logic signed [53:0] mrnd [3];
    logic signed [40:0] newp [3];
    logic signed [16:0] sneg;
    logic               do_push;
    logic               do_pop;

    function automatic t3dci_pkg::q14_t sat16(input logic signed [22:0] v);
        t3dci_pkg::q14_t r;
        if (v > 23'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -23'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic t3dci_pkg::fix_t sat32(input logic signed [40:0] v);
        t3dci_pkg::fix_t r;
        if (v > 41'sh007FFFFFFF)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -41'sh0080000000)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign busy    = (state_reg != S_IDLE);
    assign cnt_dec = cnt_reg - 1'b1;
    assign do_push = (state_reg == S_EXEC) && (op_reg.kind == t3dci_pkg::OP_PUSH)
                     && (cnt_reg != CW'(STACK_DEPTH));
    assign do_pop  = (state_reg == S_EXEC) && (op_reg.kind == t3dci_pkg::OP_POP)
                     && (cnt_reg != '0);
    assign push_data = '{x: pos_reg[0], y: pos_reg[1], z: pos_reg[2],
                         qw: o_reg[0], qx: o_reg[1], qy: o_reg[2], qz: o_reg[3]};
    assign sneg = -{cfg.sturn[15], cfg.sturn};

    // Product sums: rsum composes the orientation (row) with the turn quaternion (column); hsum forms the heading.
    always_comb
    begin
        rsum[0] = 35'(prod_reg[0][0]) - 35'(prod_reg[1][1]) - 35'(prod_reg[2][2])
                  - 35'(prod_reg[3][3]);
        rsum[1] = 35'(prod_reg[0][1]) + 35'(prod_reg[1][0]) + 35'(prod_reg[2][3])
                  - 35'(prod_reg[3][2]);
        rsum[2] = 35'(prod_reg[0][2]) - 35'(prod_reg[1][3]) + 35'(prod_reg[2][0])
                  + 35'(prod_reg[3][1]);
        rsum[3] = 35'(prod_reg[0][3]) + 35'(prod_reg[1][2]) - 35'(prod_reg[2][1])
                  + 35'(prod_reg[3][0]);
        hsum[0] = 35'(prod_reg[0][0]) + 35'(prod_reg[1][1]) - 35'(prod_reg[2][2])
                  - 35'(prod_reg[3][3]);
        hsum[1] = (35'(prod_reg[1][2]) + 35'(prod_reg[0][3])) <<< 1;
        hsum[2] = (35'(prod_reg[1][3]) - 35'(prod_reg[0][2])) <<< 1;
        for (int i = 0; i < 4; i++)
        begin
            rrnd[i] = 37'(rsum[i]) + 37'sd8192;
        end
        for (int i = 0; i < 3; i++)
        begin
            hrnd[i] = 37'(hsum[i]) + 37'sd8192;
            mrnd[i] = 54'(mv_reg[i]) + 54'sd8192;
            newp[i] = 41'(pos_reg[i]) + 41'($signed(mrnd[i][53:14]));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        o_next         = o_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        sst_next       = sst_reg;
        sen_next       = sen_reg;
        seg_valid_next = seg_valid_reg && !seg.ready;
        q_pop          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_EXEC;
                    if (q_op.new_string)
                    begin
                        pos_next = '{default: '0};
                        o_next   = '{cfg.chead, t3dci_pkg::Q_ZERO, t3dci_pkg::Q_ZERO,
                                     cfg.shead};
                        cnt_next = '0;
                    end
                end
            end
            S_EXEC:
            begin
                unique case (op_reg.kind)
                    t3dci_pkg::OP_MOVE: state_next = S_HSUM;
                    t3dci_pkg::OP_TURN: state_next = S_TSUM;
                    t3dci_pkg::OP_PUSH:
                    begin
                        state_next = S_IDLE;
                        if (do_push)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    t3dci_pkg::OP_POP:
                    begin
                        if (do_pop)
                        begin
                            cnt_next   = cnt_dec;
                            state_next = S_POPLD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_TSUM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    o_next[i] = sat16(rrnd[i][36:14]);
                end
                state_next = S_IDLE;
            end
            S_HSUM: state_next = S_MMUL;
            S_MMUL: state_next = S_MSUM;
            S_MSUM:
            begin
                if (!op_reg.draw || !seg_valid_reg || seg.ready)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_next[i] = sat32(newp[i]);
                    end
                    if (op_reg.draw)
                    begin
                        sst_next       = pos_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            sen_next[i] = sat32(newp[i]);
                        end
                        seg_valid_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_POPLD:
            begin
                pos_next   = '{rd_data_reg.x, rd_data_reg.y, rd_data_reg.z};
                o_next     = '{rd_data_reg.qw, rd_data_reg.qx, rd_data_reg.qy,
                               rd_data_reg.qz};
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            o_reg         <= '{t3dci_pkg::Q_ONE, t3dci_pkg::Q_ZERO, t3dci_pkg::Q_ZERO,
                               t3dci_pkg::Q_ZERO};
            pos_reg       <= '{default: '0};
            cnt_reg       <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            o_reg         <= o_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sst_reg <= sst_next;
        sen_reg <= sen_next;
        if (q_pop)
        begin
            op_reg <= q_op;
            unique case (q_op.axis)
                t3dci_pkg::AX_UP:
                    tq_reg <= '{17'(cfg.cturn), 17'sd0, 17'sd0,
                                q_op.neg ? sneg : 17'(cfg.sturn)};
                t3dci_pkg::AX_LEFT:
                    tq_reg <= '{17'(cfg.cturn), 17'sd0,
                                q_op.neg ? sneg : 17'(cfg.sturn), 17'sd0};
                t3dci_pkg::AX_HEAD:
                    tq_reg <= '{17'(cfg.cturn), q_op.neg ? sneg : 17'(cfg.sturn),
                                17'sd0, 17'sd0};
                default:
                    tq_reg <= '{17'sd0, 17'sd0, 17'sd0, 17'(t3dci_pkg::Q_ONE)};
            endcase
        end
        if (state_reg == S_EXEC)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (op_reg.kind == t3dci_pkg::OP_TURN)
                    begin
                        prod_reg[i][j] <= 33'(o_reg[i] * tq_reg[j]);
                    end
                    else
                    begin
                        prod_reg[i][j] <= 33'(o_reg[i] * 17'(o_reg[j]));
                    end
                end
            end
        end
        if (state_reg == S_HSUM)
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= hrnd[i][34:14];
            end
        end
        if (state_reg == S_MMUL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mv_reg[i] <= 53'(cfg.step * h_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[cnt_reg[AW-1:0]] <= push_data;
        end
        if (do_pop)
        begin
            rd_data_reg <= stack_mem[cnt_dec[AW-1:0]];
        end
    end

    assign seg.valid       = seg_valid_reg;
    assign seg.seg_start_x = sst_reg[0];
    assign seg.seg_start_y = sst_reg[1];
    assign seg.seg_start_z = sst_reg[2];
    assign seg.seg_end_x   = sen_reg[0];
    assign seg.seg_end_y   = sen_reg[1];
    assign seg.seg_end_z   = sen_reg[2];

endmodule

// ----- hdl/turtle_3d_command_interpreter.sv -----
// An accepted command is queued in the front end and dispatched when the back end is idle. A
// move runs through EXEC, HSUM, MMUL and MSUM, a turn through EXEC and TSUM, a pop of a stored
// entry through EXEC and POPLD, and anything else through EXEC only; new commands are taken in
// IDLE. A move is set by its heading multiply followed by the step multiply. An F segment beat
// is registered as MSUM ends; a pending beat blocks only the next F. Reset returns the turtle
// home, empties the stack and resets the config; stack memory stays undefined until pushed.
`include "turtle_3d_command_interpreter_macros.svh"
module turtle_3d_command_interpreter
#(
    parameter int STACK_DEPTH = t3dci_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    t3dci_cmd_if.sink                          cmd,
    t3dci_seg_if.source                        seg,
    input  logic                               cfg_we,
    input  logic [t3dci_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [t3dci_pkg::CFG_DATA_W-1:0]   cfg_data
);

    t3dci_pkg::cfg_t cfg_reg;
    logic            q_valid;
    t3dci_pkg::op_t  q_op;
    logic            q_pop;
    logic            back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{step: t3dci_pkg::STEP_RST, cturn: t3dci_pkg::Q_ONE,
                         sturn: t3dci_pkg::Q_ZERO, chead: t3dci_pkg::Q_ONE,
                         shead: t3dci_pkg::Q_ZERO};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                t3dci_pkg::CFG_STEP:  cfg_reg.step  <= cfg_data;
                t3dci_pkg::CFG_CTURN: cfg_reg.cturn <= cfg_data[15:0];
                t3dci_pkg::CFG_STURN: cfg_reg.sturn <= cfg_data[15:0];
                t3dci_pkg::CFG_CHEAD: cfg_reg.chead <= cfg_data[15:0];
                t3dci_pkg::CFG_SHEAD: cfg_reg.shead <= cfg_data[15:0];
                default:              cfg_reg       <= cfg_reg;
            endcase
        end
    end

    t3dci_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    t3dci_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .busy    (back_busy),
        .seg     (seg)
    );

    `T3DCI_ASSERT(a_pop_needs_item, q_pop, q_valid, "command queue popped while empty")
    `T3DCI_ASSERT(a_idle_dispatch, q_valid && !back_busy, q_pop, "idle back end left a command")
    `T3DCI_ASSERT_NEXT(a_pop_starts, q_pop, back_busy, "dispatched command did not start")
    `T3DCI_ASSERT(a_seg_from_exec, $rose(seg.valid), $past(back_busy), "segment without a move")

endmodule
